// ----- rtl/rank_mobius_inversion_2d_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rank Mobius inversion block
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef RANK_MOBIUS_INVERSION_2D_TOP_MACROS_SVH
`define RANK_MOBIUS_INVERSION_2D_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMI2D_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RMI2D_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rmi2d_pkg.sv -----
// ----------------------------------------------------------------------------
// rmi2d_pkg
// Sizes, codes, control word layout and the microcode program of the
// rank Mobius inversion block.
// ----------------------------------------------------------------------------
package rmi2d_pkg;

  localparam int GRID_X    = 8;
  localparam int GRID_Y    = 8;
  localparam int RANK_BITS = 16;

  localparam int COORD_BITS    = 3;
  localparam int TERM_BITS     = COORD_BITS + 1;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 4;
  localparam int MULT_BITS     = 20;
  localparam int ACC_BITS      = (RANK_BITS + 5 > MULT_BITS) ? RANK_BITS + 5 : MULT_BITS;

  localparam int STORE_DEPTH = GRID_X * GRID_Y * GRID_X * GRID_Y;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

  localparam logic signed [ACC_BITS-1:0] ACC_MULT_MAX = ACC_BITS'((1 << (MULT_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] ACC_MULT_MIN = ACC_BITS'(-(1 << (MULT_BITS - 1)));

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = CFG_IDX_BITS'(1);

  localparam logic [CFG_DATA_BITS-1:0] GRID_WIDTH_RESET  = CFG_DATA_BITS'(8);
  localparam logic [CFG_DATA_BITS-1:0] GRID_HEIGHT_RESET = CFG_DATA_BITS'(8);

  // Microcode program layout.
  localparam int STEP_BITS = 5;
  localparam int PROG_LEN  = 18;
  localparam logic [STEP_BITS-1:0] STEP_FIRST = STEP_BITS'(0);
  localparam logic [STEP_BITS-1:0] STEP_EMIT  = STEP_BITS'(17);

  localparam logic JMP_NONE       = 1'b0;
  localparam logic JMP_IF_INVALID = 1'b1;

  // One control word. offs holds the term offsets: bit 0 start x - 1,
  // bit 1 start y - 1, bit 2 end x + 1, bit 3 end y + 1.
  typedef struct packed {
    logic                 rd;
    logic [3:0]           offs;
    logic                 neg;
    logic                 acc;
    logic                 jmp;
    logic [STEP_BITS-1:0] target;
    logic                 done;
  } ucode_t;

  // Decoded control from the sequencer to the datapath.
  typedef struct packed {
    logic       rd;
    logic [3:0] offs;
    logic       neg;
    logic       acc;
    logic       emit;
  } ctrl_t;

  // Each read step issues one term; its sign is the parity of its offsets.
  // The accumulate flag adds the term read by the step before.
  function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
    ucode_t w;
    unique case (step)
      5'd0:    w = '{1'b1, 4'd0,  1'b0, 1'b0, JMP_IF_INVALID, STEP_EMIT, 1'b0};
      5'd1:    w = '{1'b1, 4'd1,  1'b1, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      5'd2:    w = '{1'b1, 4'd2,  1'b1, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      5'd3:    w = '{1'b1, 4'd3,  1'b0, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      5'd4:    w = '{1'b1, 4'd4,  1'b1, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      5'd5:    w = '{1'b1, 4'd5,  1'b0, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      5'd6:    w = '{1'b1, 4'd6,  1'b0, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      5'd7:    w = '{1'b1, 4'd7,  1'b1, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      5'd8:    w = '{1'b1, 4'd8,  1'b1, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      5'd9:    w = '{1'b1, 4'd9,  1'b0, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      5'd10:   w = '{1'b1, 4'd10, 1'b0, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      5'd11:   w = '{1'b1, 4'd11, 1'b1, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      5'd12:   w = '{1'b1, 4'd12, 1'b0, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      5'd13:   w = '{1'b1, 4'd13, 1'b1, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      5'd14:   w = '{1'b1, 4'd14, 1'b1, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      5'd15:   w = '{1'b1, 4'd15, 1'b0, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      5'd16:   w = '{1'b0, 4'd0,  1'b0, 1'b1, JMP_NONE, STEP_FIRST, 1'b0};
      default: w = '{1'b0, 4'd0,  1'b0, 1'b0, JMP_NONE, STEP_FIRST, 1'b1};
    endcase
    return w;
  endfunction

  function automatic logic [ADDR_BITS-1:0] store_addr(input logic [TERM_BITS-1:0] sx,
                                                      input logic [TERM_BITS-1:0] sy,
                                                      input logic [TERM_BITS-1:0] ex,
                                                      input logic [TERM_BITS-1:0] ey);
    int a;
    a = ((int'(sx) * GRID_Y + int'(sy)) * GRID_X + int'(ex)) * GRID_Y + int'(ey);
    return ADDR_BITS'(a);
  endfunction

endpackage

// ----- rtl/rmi2d_item_if.sv -----
// ----------------------------------------------------------------------------
// rmi2d_item_if
// Input channel: one write or query item per transfer.
// ----------------------------------------------------------------------------
interface rmi2d_item_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [rmi2d_pkg::COORD_BITS-1:0]    start_x;
  logic [rmi2d_pkg::COORD_BITS-1:0]    start_y;
  logic [rmi2d_pkg::COORD_BITS-1:0]    end_x;
  logic [rmi2d_pkg::COORD_BITS-1:0]    end_y;
  logic [15:0]                         rank_value;

  modport source (output valid, operation, start_x, start_y, end_x, end_y, rank_value,
                  input ready);
  modport sink (input valid, operation, start_x, start_y, end_x, end_y, rank_value,
                output ready);
endinterface

// ----- rtl/rmi2d_result_if.sv -----
// ----------------------------------------------------------------------------
// rmi2d_result_if
// Result channel: one multiplicity per query transfer.
// ----------------------------------------------------------------------------
interface rmi2d_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [rmi2d_pkg::MULT_BITS-1:0] multiplicity;
  logic                                   query_valid;

  modport source (output valid, multiplicity, query_valid, input ready);
  modport sink (input valid, multiplicity, query_valid, output ready);
endinterface

// ----- rtl/rmi2d_cfg_if.sv -----
// ----------------------------------------------------------------------------
// rmi2d_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rmi2d_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [rmi2d_pkg::CFG_IDX_BITS-1:0]   index;
  logic [rmi2d_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/rmi2d_ram.sv -----
// ----------------------------------------------------------------------------
// rmi2d_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module rmi2d_ram #(
  parameter int DATA_BITS = 16,
  parameter int ADDR_BITS = 12
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [DATA_BITS-1:0] wdata,
  output logic [DATA_BITS-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/rmi2d_seq.sv -----
// ----------------------------------------------------------------------------
// rmi2d_seq
// Microcode sequencer: step counter over the program ROM, with a jump to
// the result step for an invalid query and a hold there while the output
// register is full.
// ----------------------------------------------------------------------------
`include "rank_mobius_inversion_2d_top_macros.svh"

module rmi2d_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             query_ok,
  input  logic             out_free,
  output logic             busy,
  output rmi2d_pkg::ctrl_t ctrl
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                            state;
  logic                            state_next;
  logic [rmi2d_pkg::STEP_BITS-1:0] step;
  logic [rmi2d_pkg::STEP_BITS-1:0] step_next;
  rmi2d_pkg::ucode_t               word;

  assign word = rmi2d_pkg::ucode_rom(step);
  assign busy = (state == ST_RUN);

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
          step_next  = rmi2d_pkg::STEP_FIRST;
        end
      end
      ST_RUN: begin
        if (word.done) begin
          if (out_free) begin
            state_next = ST_IDLE;
          end
        end else if (word.jmp == rmi2d_pkg::JMP_IF_INVALID && !query_ok) begin
          step_next = word.target;
        end else begin
          step_next = step + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.rd   = busy && word.rd;
    ctrl.offs = word.offs;
    ctrl.neg  = word.neg;
    ctrl.acc  = busy && word.acc;
    ctrl.emit = busy && word.done && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= rmi2d_pkg::STEP_FIRST;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  `RMI2D_ASSERT_IMP(a_step_in_program, clk, rst, busy,
    step < rmi2d_pkg::STEP_BITS'(rmi2d_pkg::PROG_LEN), "step counter ran past the program")
  `RMI2D_ASSERT_NXT(a_invalid_skips, clk, rst,
    busy && step == rmi2d_pkg::STEP_FIRST && !query_ok,
    busy && step == rmi2d_pkg::STEP_EMIT, "invalid query did not jump to the result step")
  `RMI2D_ASSERT_NXT(a_emit_ends_run, clk, rst, ctrl.emit, !busy,
    "sequencer stayed busy after delivering a result")

endmodule

// ----- rtl/rmi2d_dp.sv -----
// ----------------------------------------------------------------------------
// rmi2d_dp
// Datapath: holds the query coordinates, forms the address of each term and
// of each write, masks terms outside the active grid and accumulates the signed sum.
// ----------------------------------------------------------------------------
module rmi2d_dp (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     load,
  input  logic                                     wr,
  input  logic [rmi2d_pkg::COORD_BITS-1:0]         in_start_x,
  input  logic [rmi2d_pkg::COORD_BITS-1:0]         in_start_y,
  input  logic [rmi2d_pkg::COORD_BITS-1:0]         in_end_x,
  input  logic [rmi2d_pkg::COORD_BITS-1:0]         in_end_y,
  input  logic [15:0]                              in_rank_value,
  input  logic [rmi2d_pkg::CFG_DATA_BITS-1:0]      act_w,
  input  logic [rmi2d_pkg::CFG_DATA_BITS-1:0]      act_h,
  input  rmi2d_pkg::ctrl_t                         ctrl,
  input  logic [rmi2d_pkg::RANK_BITS-1:0]          mem_rdata,
  output logic                                     mem_en,
  output logic                                     mem_we,
  output logic [rmi2d_pkg::ADDR_BITS-1:0]          mem_addr,
  output logic [rmi2d_pkg::RANK_BITS-1:0]          mem_wdata,
  output logic                                     query_ok,
  output logic signed [rmi2d_pkg::MULT_BITS-1:0]   mult
);

  logic [rmi2d_pkg::COORD_BITS-1:0]       sx;
  logic [rmi2d_pkg::COORD_BITS-1:0]       sy;
  logic [rmi2d_pkg::COORD_BITS-1:0]       ex;
  logic [rmi2d_pkg::COORD_BITS-1:0]       ey;
  logic [rmi2d_pkg::TERM_BITS-1:0]        tsx;
  logic [rmi2d_pkg::TERM_BITS-1:0]        tsy;
  logic [rmi2d_pkg::TERM_BITS-1:0]        tex;
  logic [rmi2d_pkg::TERM_BITS-1:0]        tey;
  logic                                   term_live;
  logic                                   live_q;
  logic                                   neg_q;
  logic                                   in_table;
  logic                                   ok_next;
  logic signed [rmi2d_pkg::ACC_BITS-1:0]  acc;
  logic signed [rmi2d_pkg::ACC_BITS-1:0]  term_val;

  // Term coordinates carry one extra bit so that end + 1 cannot wrap.
  assign tsx = {1'b0, sx} - rmi2d_pkg::TERM_BITS'(ctrl.offs[0]);
  assign tsy = {1'b0, sy} - rmi2d_pkg::TERM_BITS'(ctrl.offs[1]);
  assign tex = {1'b0, ex} + rmi2d_pkg::TERM_BITS'(ctrl.offs[2]);
  assign tey = {1'b0, ey} + rmi2d_pkg::TERM_BITS'(ctrl.offs[3]);

  // A term below the start edge or past the active end reads as zero.
  assign term_live = !(sx == '0 && ctrl.offs[0]) && !(sy == '0 && ctrl.offs[1]) &&
                     (rmi2d_pkg::CFG_DATA_BITS'(tex) < act_w) &&
                     (rmi2d_pkg::CFG_DATA_BITS'(tey) < act_h);

  assign in_table = (int'(in_start_x) < rmi2d_pkg::GRID_X) &&
                    (int'(in_start_y) < rmi2d_pkg::GRID_Y) &&
                    (int'(in_end_x) < rmi2d_pkg::GRID_X) &&
                    (int'(in_end_y) < rmi2d_pkg::GRID_Y);

  assign ok_next = (in_start_x <= in_end_x) && (in_start_y <= in_end_y) &&
                   (rmi2d_pkg::CFG_DATA_BITS'(in_end_x) < act_w) &&
                   (rmi2d_pkg::CFG_DATA_BITS'(in_end_y) < act_h);

  assign mem_en    = ctrl.rd || (wr && in_table);
  assign mem_we    = !ctrl.rd && wr && in_table;
  assign mem_wdata = rmi2d_pkg::RANK_BITS'(in_rank_value);

  always_comb begin
    if (ctrl.rd) begin
      mem_addr = rmi2d_pkg::store_addr(tsx, tsy, tex, tey);
    end else begin
      mem_addr = rmi2d_pkg::store_addr({1'b0, in_start_x}, {1'b0, in_start_y},
                                       {1'b0, in_end_x}, {1'b0, in_end_y});
    end
  end

  assign term_val = signed'(rmi2d_pkg::ACC_BITS'(mem_rdata));

  always_ff @(posedge clk) begin
    if (load) begin
      sx <= in_start_x;
      sy <= in_start_y;
      ex <= in_end_x;
      ey <= in_end_y;
    end
    if (ctrl.rd) begin
      live_q <= term_live;
      neg_q  <= ctrl.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_ok <= 1'b0;
      acc      <= '0;
    end else if (load) begin
      query_ok <= ok_next;
      acc      <= '0;
    end else if (ctrl.acc && live_q) begin
      acc <= neg_q ? acc - term_val : acc + term_val;
    end
  end

  always_comb begin
    if (acc > rmi2d_pkg::ACC_MULT_MAX) begin
      mult = rmi2d_pkg::MULT_BITS'(rmi2d_pkg::ACC_MULT_MAX);
    end else if (acc < rmi2d_pkg::ACC_MULT_MIN) begin
      mult = rmi2d_pkg::MULT_BITS'(rmi2d_pkg::ACC_MULT_MIN);
    end else begin
      mult = acc[rmi2d_pkg::MULT_BITS-1:0];
    end
  end

endmodule

// ----- rtl/rank_mobius_inversion_2d_top.sv -----
// ----------------------------------------------------------------------------
// rank_mobius_inversion_2d_top
// Rank table over a 2D grid of interval start and end points, with a signed
// multiplicity query by 16-term inclusion-exclusion.
//
// The item channel carries writes and queries. A write stores rank_value at
// (start_x, start_y, end_x, end_y) in the cycle of its transfer and gives no
// result; the next item can follow in the next cycle. A query runs a
// microcoded program that reads the sixteen neighboring entries from one
// single-port RAM, one read per cycle, and accumulates them with their signs.
// Its result then enters the output register, and the next item is taken
// only once it has. An invalid query skips the reads after the first and
// gives multiplicity 0 with query_valid low. The config channel is always
// ready; the user must write grid_width and grid_height only while the block
// is idle, which the block does not enforce. Reset sets both to 8 and idles
// the sequencer; the RAM is not cleared, so the user must write an entry
// before a query reads it, which the block does not enforce.
// When the result receiver stalls, a finished result waits in the output
// register and the sequencer holds at its last step.
// ----------------------------------------------------------------------------
`include "rank_mobius_inversion_2d_top_macros.svh"

module rank_mobius_inversion_2d_top (
  input  logic                  clk,
  input  logic                  rst,
  rmi2d_item_if.sink            item,
  rmi2d_result_if.source        result,
  rmi2d_cfg_if.sink             cfg
);

  logic [rmi2d_pkg::CFG_DATA_BITS-1:0]    grid_width;
  logic [rmi2d_pkg::CFG_DATA_BITS-1:0]    grid_height;
  logic [rmi2d_pkg::CFG_DATA_BITS-1:0]    act_w;
  logic [rmi2d_pkg::CFG_DATA_BITS-1:0]    act_h;
  logic                                   item_xfer;
  logic                                   load;
  logic                                   wr;
  logic                                   busy;
  logic                                   query_ok;
  logic                                   out_free;
  logic                                   out_valid;
  logic signed [rmi2d_pkg::MULT_BITS-1:0] out_mult;
  logic                                   out_qv;
  logic signed [rmi2d_pkg::MULT_BITS-1:0] mult;
  rmi2d_pkg::ctrl_t                       ctrl;
  logic                                   mem_en;
  logic                                   mem_we;
  logic [rmi2d_pkg::ADDR_BITS-1:0]        mem_addr;
  logic [rmi2d_pkg::RANK_BITS-1:0]        mem_wdata;
  logic [rmi2d_pkg::RANK_BITS-1:0]        mem_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= rmi2d_pkg::GRID_WIDTH_RESET;
      grid_height <= rmi2d_pkg::GRID_HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        rmi2d_pkg::REG_GRID_WIDTH:  grid_width  <= cfg.data;
        rmi2d_pkg::REG_GRID_HEIGHT: grid_height <= cfg.data;
        default: ;
      endcase
    end
  end

  assign act_w = (int'(grid_width) < rmi2d_pkg::GRID_X) ?
                 grid_width : rmi2d_pkg::CFG_DATA_BITS'(rmi2d_pkg::GRID_X);
  assign act_h = (int'(grid_height) < rmi2d_pkg::GRID_Y) ?
                 grid_height : rmi2d_pkg::CFG_DATA_BITS'(rmi2d_pkg::GRID_Y);

  assign item.ready = !busy;
  assign item_xfer  = item.valid && item.ready;
  assign load       = item_xfer && (item.operation == rmi2d_pkg::OP_QUERY);
  assign wr         = item_xfer && (item.operation == rmi2d_pkg::OP_WRITE);
  assign out_free   = !out_valid || result.ready;

  rmi2d_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (load),
    .query_ok (query_ok),
    .out_free (out_free),
    .busy     (busy),
    .ctrl     (ctrl)
  );

  rmi2d_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .wr            (wr),
    .in_start_x    (item.start_x),
    .in_start_y    (item.start_y),
    .in_end_x      (item.end_x),
    .in_end_y      (item.end_y),
    .in_rank_value (item.rank_value),
    .act_w         (act_w),
    .act_h         (act_h),
    .ctrl          (ctrl),
    .mem_rdata     (mem_rdata),
    .mem_en        (mem_en),
    .mem_we        (mem_we),
    .mem_addr      (mem_addr),
    .mem_wdata     (mem_wdata),
    .query_ok      (query_ok),
    .mult          (mult)
  );

  rmi2d_ram #(
    .DATA_BITS (rmi2d_pkg::RANK_BITS),
    .ADDR_BITS (rmi2d_pkg::ADDR_BITS)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_mult <= mult;
      out_qv   <= query_ok;
    end
  end

  assign result.valid        = out_valid;
  assign result.multiplicity = out_mult;
  assign result.query_valid  = out_qv;

  `RMI2D_ASSERT_NXT(a_query_starts_run, clk, rst,
    item_xfer && item.operation == rmi2d_pkg::OP_QUERY, busy,
    "query transfer did not start the sequencer")
  `RMI2D_ASSERT_NXT(a_write_stays_idle, clk, rst,
    item_xfer && item.operation == rmi2d_pkg::OP_WRITE, !busy,
    "write transfer left the sequencer busy")
  `RMI2D_ASSERT_IMP(a_invalid_is_zero, clk, rst, out_valid && !out_qv, out_mult == '0,
    "invalid query produced a nonzero multiplicity")

endmodule
